@@ rtl/rect_duct_point_velocity_correction_core_assert.svh @@
// assertion macros for the point velocity correction core
// used by the top level only; expects aclk and aresetn in scope
`ifndef RECT_DUCT_POINT_VELOCITY_CORRECTION_CORE_ASSERT_SVH
`define RECT_DUCT_POINT_VELOCITY_CORRECTION_CORE_ASSERT_SVH

// same-cycle implication
`define RDPVC_ASSERT(label, ante, cons, msg) \
    label: assert property (@(posedge aclk) disable iff (!aresetn) (ante) |-> (cons)) \
        else $error(msg);

// next-cycle implication
`define RDPVC_ASSERT_NEXT(label, ante, cons, msg) \
    label: assert property (@(posedge aclk) disable iff (!aresetn) (ante) |=> (cons)) \
        else $error(msg);

`endif

@@ rtl/rdpvc_pkg.sv @@
// shared constants, status codes and stage payload type
// for the point velocity correction core; no dependencies
package rdpvc_pkg;

    localparam int FRAC_BITS = 16;

    localparam logic [63:0] ONE  = 64'd1 << FRAC_BITS;
    localparam logic [63:0] HALF = 64'd1 << (FRAC_BITS - 1);

    localparam logic [2:0] ST_OK         = 3'd0;
    localparam logic [2:0] ST_BAD_GEOM   = 3'd1;
    localparam logic [2:0] ST_OUTSIDE    = 3'd2;
    localparam logic [2:0] ST_BAD_VEL    = 3'd3;
    localparam logic [2:0] ST_BAD_ROUGH  = 3'd4;
    localparam logic [2:0] ST_NEAR_WALL  = 3'd5;
    localparam logic [2:0] ST_NOT_APPL   = 3'd6;

    localparam logic [1:0] CFG_WIDTH  = 2'd0;
    localparam logic [1:0] CFG_HEIGHT = 2'd1;
    localparam logic [1:0] CFG_ROUGH  = 2'd2;

    localparam logic [21:0] W_RESET = 22'd323748;
    localparam logic [21:0] H_RESET = 22'd224788;
    localparam logic [15:0] E_RESET = 16'd360;

    localparam logic [63:0] W_TESTED = (64'd494 * ONE + 64'd50) / 64'd100;
    localparam logic [63:0] H_TESTED = (64'd343 * ONE + 64'd50) / 64'd100;
    localparam logic [63:0] E_MIN    = (ONE + 64'd999) / 64'd1000;
    localparam logic [63:0] E_MAX    = (64'd9 * ONE) / 64'd1000;
    localparam logic [63:0] E_REF    = (64'd55 * ONE + 64'd5000) / 64'd10000;
    localparam logic [63:0] NEAR_MAX = (64'd2 * ONE - 64'd1) / 64'd5;

    localparam logic signed [25:0] C34 = 26'((64'd34 * ONE + 64'd5) / 64'd10);
    localparam logic signed [25:0] C19 = 26'((64'd19 * ONE + 64'd5) / 64'd10);

    localparam logic signed [29:0] LN2_Q29     = 30'sd372130559;
    localparam int                 ROUND_SHIFT = 57 - FRAC_BITS;
    localparam logic signed [63:0] RND_HALF    = 64'sd1 <<< (ROUND_SHIFT - 1);

    localparam int LOG_IN_W = 24;
    localparam int LOG_W    = $clog2(LOG_IN_W) + 28;

    typedef struct packed {
        logic [2:0]  status;
        logic        tested;
        logic        near_wall;
        logic        ref_rough;
        logic [21:0] velocity;
        logic [15:0] rough;
        logic [28:0] area;
        logic        harm_zero;
    } item_t;

endpackage

@@ rtl/rdpvc_div.sv @@
// pipelined restoring divider, one quotient bit per stage, with overflow flag
// standalone; used by the point velocity correction core
module rdpvc_div #(
    parameter int NW = 47,
    parameter int DW = 24,
    parameter int QW = 24
) (
    input  logic          aclk,
    input  logic          en,
    input  logic [NW-1:0] numer,
    input  logic [DW-1:0] denom,
    output logic [QW-1:0] quot,
    output logic          ovf
);
    localparam int HW = NW - QW;
    localparam int CW = (HW > DW) ? HW : DW;

    logic [DW-1:0] rem_reg [0:QW];
    logic [QW-1:0] nlo_reg [0:QW];
    logic [QW-1:0] q_reg   [0:QW];
    logic [DW-1:0] d_reg   [0:QW];
    logic          ovf_reg [0:QW];

    logic [HW-1:0] hi;
    logic          ovf_next;

    assign hi       = numer[NW-1:QW];
    assign ovf_next = CW'(hi) >= CW'(denom);

    always_ff @(posedge aclk) begin
        if (en) begin
            rem_reg[0] <= DW'(hi);
            nlo_reg[0] <= numer[QW-1:0];
            q_reg[0]   <= '0;
            d_reg[0]   <= denom;
            ovf_reg[0] <= ovf_next;
        end
    end

    for (genvar i = 1; i <= QW; i++) begin : g_stage
        logic [DW:0] rr;
        logic [DW:0] df;
        logic        ge;

        assign rr = {rem_reg[i-1], nlo_reg[i-1][QW-1]};
        assign df = rr - {1'b0, d_reg[i-1]};
        assign ge = rr >= {1'b0, d_reg[i-1]};

        always_ff @(posedge aclk) begin
            if (en) begin
                rem_reg[i] <= ge ? df[DW-1:0] : rr[DW-1:0];
                nlo_reg[i] <= {nlo_reg[i-1][QW-2:0], 1'b0};
                q_reg[i]   <= {q_reg[i-1][QW-2:0], ge};
                d_reg[i]   <= d_reg[i-1];
                ovf_reg[i] <= ovf_reg[i-1];
            end
        end
    end

    assign quot = q_reg[QW];
    assign ovf  = ovf_reg[QW];

endmodule

@@ rtl/rdpvc_log.sv @@
// pipelined base-2 logarithm: msb position plus 28 fraction bits by repeated squaring
// standalone; used by the point velocity correction core
module rdpvc_log #(
    parameter int IW = 24
) (
    input  logic                      aclk,
    input  logic                      en,
    input  logic [IW-1:0]             din,
    output logic [$clog2(IW)+27:0]    log2_q
);
    localparam int PW    = $clog2(IW);
    localparam int STEPS = 28;

    logic [30:0]      m_reg    [0:STEPS];
    logic [STEPS-1:0] frac_reg [0:STEPS];
    logic [PW-1:0]    p_reg    [0:STEPS];

    logic [PW-1:0] p_next;
    logic [4:0]    sh_next;

    always_comb begin
        p_next = '0;
        for (int i = 0; i < IW; i++) begin
            if (din[i]) begin
                p_next = PW'(i);
            end
        end
        sh_next = 5'd30 - 5'(p_next);
    end

    always_ff @(posedge aclk) begin
        if (en) begin
            m_reg[0]    <= 31'(din) << sh_next;
            frac_reg[0] <= '0;
            p_reg[0]    <= p_next;
        end
    end

    for (genvar k = 1; k <= STEPS; k++) begin : g_square
        logic [61:0] sq;
        logic [31:0] t;

        assign sq = m_reg[k-1] * m_reg[k-1];
        assign t  = sq[61:30];

        always_ff @(posedge aclk) begin
            if (en) begin
                m_reg[k]    <= t[31] ? t[31:1] : t[30:0];
                frac_reg[k] <= {frac_reg[k-1][STEPS-2:0], t[31]};
                p_reg[k]    <= p_reg[k-1];
            end
        end
    end

    assign log2_q = {p_reg[STEPS], frac_reg[STEPS]};

endmodule

@@ rtl/rect_duct_point_velocity_correction_core.sv @@
// Point velocity correction for a rectangular duct. One reading is taken per clock
// while the result side does not stall; the dividers produce one quotient bit per stage
// (25 and 23 stages) and the log units work by repeated squaring (29 stages).
// When the result side stalls the whole pipeline holds. Configuration writes take
// effect for readings accepted afterwards and must be made with the pipeline empty.
// Depends on rdpvc_pkg, rdpvc_div, rdpvc_log and the assertion macro header.
`include "rect_duct_point_velocity_correction_core_assert.svh"

module rect_duct_point_velocity_correction_core (
    input  logic         aclk,
    input  logic         aresetn,
    input  logic         s_tvalid,
    output logic         s_tready,
    input  logic [71:0]  s_tdata,   // sensor_x, sensor_y, point_velocity
    output logic         m_tvalid,
    input  logic         m_tready,
    output logic [103:0] m_tdata,   // correction_factor, mean_velocity, max_velocity, air_volume
    output logic [5:0]   m_tuser,   // status, tested_config, near_wall_warning, reference_roughness
    input  logic         cfg_valid,
    output logic         cfg_ready,
    input  logic [1:0]   cfg_index,
    input  logic [21:0]  cfg_data
);
    import rdpvc_pkg::*;

    localparam int DIV1_NW  = 47;
    localparam int DIV1_DW  = 24;
    localparam int DIV1_QW  = 24;
    localparam int DIV1_LAT = DIV1_QW + 1;
    localparam int DIV2_NW  = 44;
    localparam int DIV2_DW  = 22;
    localparam int DIV2_QW  = 22;
    localparam int DIV2_LAT = DIV2_QW + 1;
    localparam int LOG_LAT  = 29;

    logic adv;
    assign adv       = !m_tvalid || m_tready;
    assign s_tready  = adv;
    assign cfg_ready = 1'b1;

    // configuration
    logic [21:0] width_reg, height_reg;
    logic [15:0] rough_reg;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            width_reg  <= W_RESET;
            height_reg <= H_RESET;
            rough_reg  <= E_RESET;
        end else if (cfg_valid && cfg_ready) begin
            unique case (cfg_index)
                CFG_WIDTH:  width_reg  <= cfg_data;
                CFG_HEIGHT: height_reg <= cfg_data;
                CFG_ROUGH:  rough_reg  <= cfg_data[15:0];
                default: ;
            endcase
        end
    end

    // stage 1: input capture
    logic        s1_valid_reg;
    logic [21:0] s1_x_reg, s1_y_reg, s1_v_reg, s1_w_reg, s1_h_reg;
    logic [15:0] s1_e_reg;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            s1_valid_reg <= 1'b0;
        end else if (adv) begin
            s1_valid_reg <= s_tvalid;
        end
    end

    always_ff @(posedge aclk) begin
        if (adv) begin
            s1_x_reg <= s_tdata[21:0];
            s1_y_reg <= s_tdata[43:22];
            s1_v_reg <= s_tdata[65:44];
            s1_w_reg <= width_reg;
            s1_h_reg <= height_reg;
            s1_e_reg <= rough_reg;
        end
    end

    // stage 2: products, center offsets, early checks
    logic        s2_valid_reg;
    item_t       s2_item_reg, s2_item_next;
    logic [43:0] s2_wh_reg, s2_wh_next;
    logic [22:0] s2_sum_reg, s2_sum_next;
    logic [22:0] s2_a2_reg, s2_a2_next, s2_b2_reg, s2_b2_next;
    logic        s2_dz_reg, s2_dz_next;

    logic [22:0] tx, ty, wx, hy;
    logic [21:0] w_minus_x, h_minus_y;

    always_comb begin
        tx          = {s1_x_reg, 1'b0};
        ty          = {s1_y_reg, 1'b0};
        wx          = {1'b0, s1_w_reg};
        hy          = {1'b0, s1_h_reg};
        w_minus_x   = s1_w_reg - s1_x_reg;
        h_minus_y   = s1_h_reg - s1_y_reg;
        s2_wh_next  = 44'(s1_w_reg) * 44'(s1_h_reg);
        s2_sum_next = 23'(s1_w_reg) + 23'(s1_h_reg);
        s2_a2_next  = (tx >= wx) ? tx - wx : wx - tx;
        s2_b2_next  = (ty >= hy) ? ty - hy : hy - ty;
        s2_dz_next  = (s1_x_reg == '0) || (w_minus_x == '0) ||
                      (s1_y_reg == '0) || (h_minus_y == '0);

        s2_item_next = '0;
        priority if (s1_w_reg == '0 || s1_h_reg == '0) begin
            s2_item_next.status = ST_BAD_GEOM;
        end else if (s1_x_reg > s1_w_reg || s1_y_reg > s1_h_reg) begin
            s2_item_next.status = ST_OUTSIDE;
        end else if (s1_v_reg == '0) begin
            s2_item_next.status = ST_BAD_VEL;
        end else begin
            s2_item_next.status = ST_OK;
        end
        s2_item_next.tested = (s1_w_reg == 22'(W_TESTED)) && (s1_h_reg == 22'(H_TESTED)) &&
                              (s1_e_reg >= 16'(E_MIN)) && (s1_e_reg <= 16'(E_MAX));
        s2_item_next.near_wall = (s1_x_reg <= 22'(NEAR_MAX)) || (w_minus_x <= 22'(NEAR_MAX)) ||
                                 (s1_y_reg <= 22'(NEAR_MAX)) || (h_minus_y <= 22'(NEAR_MAX));
        s2_item_next.ref_rough = (s1_e_reg == 16'(E_REF));
        s2_item_next.velocity  = s1_v_reg;
        s2_item_next.rough     = s1_e_reg;
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            s2_valid_reg <= 1'b0;
        end else if (adv) begin
            s2_valid_reg <= s1_valid_reg;
        end
    end

    always_ff @(posedge aclk) begin
        if (adv) begin
            s2_item_reg <= s2_item_next;
            s2_wh_reg   <= s2_wh_next;
            s2_sum_reg  <= s2_sum_next;
            s2_a2_reg   <= s2_a2_next;
            s2_b2_reg   <= s2_b2_next;
            s2_dz_reg   <= s2_dz_next;
        end
    end

    // stage 3: roughness product, offset product, area
    logic        s3_valid_reg;
    item_t       s3_item_reg, s3_item_next;
    logic [43:0] s3_wh_reg;
    logic [22:0] s3_sum_reg;
    logic [38:0] s3_ewh_reg, s3_ewh_next;
    logic [45:0] s3_ab_reg, s3_ab_next;
    logic [23:0] s3_sab_reg, s3_sab_next;
    logic        s3_dz_reg;
    logic [44:0] area_full;

    always_comb begin
        s3_ewh_next = 39'(s2_item_reg.rough) * 39'(s2_sum_reg);
        s3_ab_next  = 46'(s2_a2_reg) * 46'(s2_b2_reg);
        s3_sab_next = 24'(s2_a2_reg) + 24'(s2_b2_reg);
        area_full   = 45'(s2_wh_reg) + 45'(HALF);
        s3_item_next      = s2_item_reg;
        s3_item_next.area = area_full[FRAC_BITS +: 29];
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            s3_valid_reg <= 1'b0;
        end else if (adv) begin
            s3_valid_reg <= s2_valid_reg;
        end
    end

    always_ff @(posedge aclk) begin
        if (adv) begin
            s3_item_reg <= s3_item_next;
            s3_wh_reg   <= s2_wh_reg;
            s3_sum_reg  <= s2_sum_reg;
            s3_ewh_reg  <= s3_ewh_next;
            s3_ab_reg   <= s3_ab_next;
            s3_sab_reg  <= s3_sab_next;
            s3_dz_reg   <= s2_dz_reg;
        end
    end

    // stage 4: roughness and wall checks, rounded numerators
    logic               s4_valid_reg;
    item_t              s4_item_reg, s4_item_next;
    logic [DIV1_NW-1:0] s4_n1_reg, s4_n1_next, s4_n2_reg, s4_n2_next;
    logic [DIV1_DW-1:0] s4_d1_reg, s4_d2_reg;

    always_comb begin
        s4_item_next = s3_item_reg;
        if (s3_item_reg.status == ST_OK) begin
            if (s3_item_reg.rough == '0 || 44'(s3_ewh_reg) >= s3_wh_reg) begin
                s4_item_next.status = ST_BAD_ROUGH;
            end else if (s3_dz_reg) begin
                s4_item_next.status = ST_NEAR_WALL;
            end
        end
        s4_item_next.harm_zero = (s3_sab_reg == '0);
        s4_n1_next = DIV1_NW'(s3_wh_reg) + DIV1_NW'(s3_sum_reg >> 1);
        s4_n2_next = DIV1_NW'(s3_ab_reg) + DIV1_NW'(s3_sab_reg >> 1);
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            s4_valid_reg <= 1'b0;
        end else if (adv) begin
            s4_valid_reg <= s3_valid_reg;
        end
    end

    always_ff @(posedge aclk) begin
        if (adv) begin
            s4_item_reg <= s4_item_next;
            s4_n1_reg   <= s4_n1_next;
            s4_n2_reg   <= s4_n2_next;
            s4_d1_reg   <= DIV1_DW'(s3_sum_reg);
            s4_d2_reg   <= s3_sab_reg;
        end
    end

    // equivalent radius and harmonic center distance
    logic [DIV1_QW-1:0] rq_q, harm_q;
    logic               rq_ovf, harm_ovf;

    rdpvc_div #(.NW(DIV1_NW), .DW(DIV1_DW), .QW(DIV1_QW)) u_div_radius (
        .aclk  (aclk),
        .en    (adv),
        .numer (s4_n1_reg),
        .denom (s4_d1_reg),
        .quot  (rq_q),
        .ovf   (rq_ovf)
    );

    rdpvc_div #(.NW(DIV1_NW), .DW(DIV1_DW), .QW(DIV1_QW)) u_div_harm (
        .aclk  (aclk),
        .en    (adv),
        .numer (s4_n2_reg),
        .denom (s4_d2_reg),
        .quot  (harm_q),
        .ovf   (harm_ovf)
    );

    logic  dl1_valid_reg [0:DIV1_LAT-1];
    item_t dl1_item_reg  [0:DIV1_LAT-1];

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            for (int i = 0; i < DIV1_LAT; i++) dl1_valid_reg[i] <= 1'b0;
        end else if (adv) begin
            dl1_valid_reg[0] <= s4_valid_reg;
            for (int i = 1; i < DIV1_LAT; i++) dl1_valid_reg[i] <= dl1_valid_reg[i-1];
        end
    end

    always_ff @(posedge aclk) begin
        if (adv) begin
            dl1_item_reg[0] <= s4_item_reg;
            for (int i = 1; i < DIV1_LAT; i++) dl1_item_reg[i] <= dl1_item_reg[i-1];
        end
    end

    // stage 5: wall distance
    logic                s5_valid_reg;
    item_t               s5_item_reg, s5_item_next;
    logic [LOG_IN_W-1:0] s5_d_reg, s5_d_next, s5_rq_reg, s5_e_reg;
    logic [DIV1_QW-1:0]  harm_sel;
    logic signed [DIV1_QW:0] wall_d;

    always_comb begin
        s5_item_next = dl1_item_reg[DIV1_LAT-1];
        harm_sel     = s5_item_next.harm_zero ? '0 : harm_q;
        wall_d       = $signed({1'b0, rq_q}) - $signed({1'b0, harm_sel});
        s5_d_next    = LOG_IN_W'(1);
        if (wall_d > 0) begin
            s5_d_next = wall_d[LOG_IN_W-1:0];
        end else if (s5_item_next.status == ST_OK) begin
            s5_item_next.status = ST_NEAR_WALL;
        end
        if (rq_ovf || harm_ovf) begin
            s5_item_next.harm_zero = s5_item_next.harm_zero;
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            s5_valid_reg <= 1'b0;
        end else if (adv) begin
            s5_valid_reg <= dl1_valid_reg[DIV1_LAT-1];
        end
    end

    always_ff @(posedge aclk) begin
        if (adv) begin
            s5_item_reg <= s5_item_next;
            s5_d_reg    <= s5_d_next;
            s5_rq_reg   <= LOG_IN_W'(rq_q);
            s5_e_reg    <= LOG_IN_W'(dl1_item_reg[DIV1_LAT-1].rough);
        end
    end

    // logarithms
    logic [LOG_W-1:0] log_d, log_r, log_e;

    rdpvc_log #(.IW(LOG_IN_W)) u_log_dist (
        .aclk (aclk), .en (adv), .din (s5_d_reg), .log2_q (log_d)
    );

    rdpvc_log #(.IW(LOG_IN_W)) u_log_radius (
        .aclk (aclk), .en (adv), .din (s5_rq_reg), .log2_q (log_r)
    );

    rdpvc_log #(.IW(LOG_IN_W)) u_log_rough (
        .aclk (aclk), .en (adv), .din (s5_e_reg), .log2_q (log_e)
    );

    logic  dl2_valid_reg [0:LOG_LAT-1];
    item_t dl2_item_reg  [0:LOG_LAT-1];

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            for (int i = 0; i < LOG_LAT; i++) dl2_valid_reg[i] <= 1'b0;
        end else if (adv) begin
            dl2_valid_reg[0] <= s5_valid_reg;
            for (int i = 1; i < LOG_LAT; i++) dl2_valid_reg[i] <= dl2_valid_reg[i-1];
        end
    end

    always_ff @(posedge aclk) begin
        if (adv) begin
            dl2_item_reg[0] <= s5_item_reg;
            for (int i = 1; i < LOG_LAT; i++) dl2_item_reg[i] <= dl2_item_reg[i-1];
        end
    end

    // stages 6 to 9: log differences, scale by ln2, round, add offsets
    logic                    s6_valid_reg, s7_valid_reg, s8_valid_reg, s9_valid_reg;
    item_t                   s6_item_reg, s7_item_reg, s8_item_reg, s9_item_reg, s9_item_next;
    logic signed [LOG_W:0]   s6_dd_reg, s6_dr_reg;
    logic signed [63:0]      s7_pd_reg, s7_pd_next, s7_pr_reg, s7_pr_next;
    logic signed [63:0]      ld_full, lr_full;
    logic signed [24:0]      s8_ld_reg, s8_lr_reg;
    logic signed [25:0]      num_s, den_s, mx_s;
    logic [21:0]             s9_num_reg, s9_den_reg, s9_mx_reg;

    always_comb begin
        s7_pd_next = s6_dd_reg * LN2_Q29;
        s7_pr_next = s6_dr_reg * LN2_Q29;
        ld_full    = (s7_pd_reg + RND_HALF) >>> ROUND_SHIFT;
        lr_full    = (s7_pr_reg + RND_HALF) >>> ROUND_SHIFT;
        num_s      = s8_ld_reg + C34;
        den_s      = s8_lr_reg + C19;
        mx_s       = s8_lr_reg + C34;
        s9_item_next = s8_item_reg;
        if (s8_item_reg.status == ST_OK &&
            (num_s <= 26'sd0 || den_s <= 26'sd0 || mx_s <= 26'sd0)) begin
            s9_item_next.status = ST_NOT_APPL;
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            s6_valid_reg <= 1'b0;
            s7_valid_reg <= 1'b0;
            s8_valid_reg <= 1'b0;
            s9_valid_reg <= 1'b0;
        end else if (adv) begin
            s6_valid_reg <= dl2_valid_reg[LOG_LAT-1];
            s7_valid_reg <= s6_valid_reg;
            s8_valid_reg <= s7_valid_reg;
            s9_valid_reg <= s8_valid_reg;
        end
    end

    always_ff @(posedge aclk) begin
        if (adv) begin
            s6_item_reg <= dl2_item_reg[LOG_LAT-1];
            s6_dd_reg   <= $signed({1'b0, log_d}) - $signed({1'b0, log_e});
            s6_dr_reg   <= $signed({1'b0, log_r}) - $signed({1'b0, log_e});
            s7_item_reg <= s6_item_reg;
            s7_pd_reg   <= s7_pd_next;
            s7_pr_reg   <= s7_pr_next;
            s8_item_reg <= s7_item_reg;
            s8_ld_reg   <= ld_full[24:0];
            s8_lr_reg   <= lr_full[24:0];
            s9_item_reg <= s9_item_next;
            s9_num_reg  <= num_s[21:0];
            s9_den_reg  <= den_s[21:0];
            s9_mx_reg   <= mx_s[21:0];
        end
    end

    // stages 10 and 11: velocity products and rounded numerators
    logic               s10_valid_reg, s11_valid_reg;
    item_t              s10_item_reg, s11_item_reg;
    logic [43:0]        s10_pm_reg, s10_px_reg;
    logic [21:0]        s10_num_reg, s10_den_reg, s11_num_reg;
    logic [DIV2_NW-1:0] s11_nc_reg, s11_nm_reg, s11_nx_reg;
    logic [DIV2_NW-1:0] half_num;

    assign half_num = DIV2_NW'(s10_num_reg >> 1);

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            s10_valid_reg <= 1'b0;
            s11_valid_reg <= 1'b0;
        end else if (adv) begin
            s10_valid_reg <= s9_valid_reg;
            s11_valid_reg <= s10_valid_reg;
        end
    end

    always_ff @(posedge aclk) begin
        if (adv) begin
            s10_item_reg <= s9_item_reg;
            s10_pm_reg   <= 44'(s9_item_reg.velocity) * 44'(s9_den_reg);
            s10_px_reg   <= 44'(s9_item_reg.velocity) * 44'(s9_mx_reg);
            s10_num_reg  <= s9_num_reg;
            s10_den_reg  <= s9_den_reg;
            s11_item_reg <= s10_item_reg;
            s11_nc_reg   <= (DIV2_NW'(s10_den_reg) << FRAC_BITS) + half_num;
            s11_nm_reg   <= DIV2_NW'(s10_pm_reg) + half_num;
            s11_nx_reg   <= DIV2_NW'(s10_px_reg) + half_num;
            s11_num_reg  <= s10_num_reg;
        end
    end

    // correction, mean and maximum divisions
    logic [DIV2_QW-1:0] cf_q, mean_q, max_q;
    logic               cf_ovf, mean_ovf, max_ovf;

    rdpvc_div #(.NW(DIV2_NW), .DW(DIV2_DW), .QW(DIV2_QW)) u_div_cf (
        .aclk (aclk), .en (adv), .numer (s11_nc_reg), .denom (s11_num_reg),
        .quot (cf_q), .ovf (cf_ovf)
    );

    rdpvc_div #(.NW(DIV2_NW), .DW(DIV2_DW), .QW(DIV2_QW)) u_div_mean (
        .aclk (aclk), .en (adv), .numer (s11_nm_reg), .denom (s11_num_reg),
        .quot (mean_q), .ovf (mean_ovf)
    );

    rdpvc_div #(.NW(DIV2_NW), .DW(DIV2_DW), .QW(DIV2_QW)) u_div_max (
        .aclk (aclk), .en (adv), .numer (s11_nx_reg), .denom (s11_num_reg),
        .quot (max_q), .ovf (max_ovf)
    );

    logic  dl3_valid_reg [0:DIV2_LAT-1];
    item_t dl3_item_reg  [0:DIV2_LAT-1];

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            for (int i = 0; i < DIV2_LAT; i++) dl3_valid_reg[i] <= 1'b0;
        end else if (adv) begin
            dl3_valid_reg[0] <= s11_valid_reg;
            for (int i = 1; i < DIV2_LAT; i++) dl3_valid_reg[i] <= dl3_valid_reg[i-1];
        end
    end

    always_ff @(posedge aclk) begin
        if (adv) begin
            dl3_item_reg[0] <= s11_item_reg;
            for (int i = 1; i < DIV2_LAT; i++) dl3_item_reg[i] <= dl3_item_reg[i-1];
        end
    end

    // stages 12 and 13: saturation, volume product
    logic        s12_valid_reg, s13_valid_reg;
    item_t       s12_item_reg, s13_item_reg;
    logic [19:0] s12_cf_reg, s13_cf_reg;
    logic [21:0] s12_mean_reg, s12_max_reg, s13_mean_reg, s13_max_reg;
    logic [50:0] s13_air_prod_reg;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            s12_valid_reg <= 1'b0;
            s13_valid_reg <= 1'b0;
        end else if (adv) begin
            s12_valid_reg <= dl3_valid_reg[DIV2_LAT-1];
            s13_valid_reg <= s12_valid_reg;
        end
    end

    always_ff @(posedge aclk) begin
        if (adv) begin
            s12_item_reg     <= dl3_item_reg[DIV2_LAT-1];
            s12_cf_reg       <= (cf_ovf || cf_q[21:20] != 2'b00) ? '1 : cf_q[19:0];
            s12_mean_reg     <= mean_ovf ? '1 : mean_q;
            s12_max_reg      <= max_ovf ? '1 : max_q;
            s13_item_reg     <= s12_item_reg;
            s13_cf_reg       <= s12_cf_reg;
            s13_mean_reg     <= s12_mean_reg;
            s13_max_reg      <= s12_max_reg;
            s13_air_prod_reg <= 51'(s12_item_reg.area) * 51'(s12_mean_reg);
        end
    end

    // output register
    logic        out_valid_reg;
    logic [2:0]  out_status_reg;
    logic [19:0] out_cf_reg;
    logic [21:0] out_mean_reg, out_max_reg;
    logic [33:0] out_air_reg, air_next;
    logic        out_tested_reg, out_near_reg, out_refr_reg;
    logic [51:0] air_rnd;
    logic        ok13;

    always_comb begin
        air_rnd  = 52'(s13_air_prod_reg) + 52'(HALF);
        air_next = (air_rnd[51:FRAC_BITS] > 36'(34'h3_FFFF_FFFF)) ? '1
                                                                 : air_rnd[FRAC_BITS +: 34];
        ok13     = (s13_item_reg.status == ST_OK);
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            out_valid_reg <= 1'b0;
        end else if (adv) begin
            out_valid_reg <= s13_valid_reg;
        end
    end

    always_ff @(posedge aclk) begin
        if (adv) begin
            out_status_reg <= s13_item_reg.status;
            out_cf_reg     <= ok13 ? s13_cf_reg : '0;
            out_mean_reg   <= ok13 ? s13_mean_reg : '0;
            out_max_reg    <= ok13 ? s13_max_reg : '0;
            out_air_reg    <= ok13 ? air_next : '0;
            out_tested_reg <= ok13 && s13_item_reg.tested;
            out_near_reg   <= ok13 && s13_item_reg.near_wall;
            out_refr_reg   <= ok13 && s13_item_reg.ref_rough;
        end
    end

    assign m_tvalid = out_valid_reg;
    assign m_tdata  = {6'b0, out_air_reg, out_max_reg, out_mean_reg, out_cf_reg};
    assign m_tuser  = {out_refr_reg, out_near_reg, out_tested_reg, out_status_reg};

    // checks
    `RDPVC_ASSERT(a_fault_clears_fields, out_valid_reg && out_status_reg != ST_OK, out_cf_reg == '0 && out_mean_reg == '0 && out_max_reg == '0 && out_air_reg == '0 && !out_tested_reg && !out_near_reg && !out_refr_reg, "fields not cleared on fault status")
    `RDPVC_ASSERT(a_mean_not_above_max, out_valid_reg && out_status_reg == ST_OK, out_mean_reg <= out_max_reg, "mean velocity above maximum velocity")
    `RDPVC_ASSERT_NEXT(a_stall_freezes_pipe, out_valid_reg && !m_tready, $stable(s13_valid_reg) && $stable(s13_air_prod_reg) && $stable(s5_d_reg) && $stable(s1_valid_reg), "pipeline moved during output stall")

endmodule
